// File: rtl/csei_pkg.sv
// ----------------------------------------------------------------------------
// csei_pkg: constants for cold-start enrichment interpolation
// Breakpoint and percentage tables, per-segment slopes and the reciprocal
// used to divide the scaled pulse width by one hundred.
// ----------------------------------------------------------------------------
package csei_pkg;

	localparam int BASE_W = 16;
	localparam int TEMP_W = 9;
	localparam int PCT_W = 9;
	localparam int SEG_W = 3;
	localparam int DT_W = 5;
	localparam int STEP_W = 8;
	localparam int PROD_W = BASE_W + PCT_W;
	localparam int DATA_W = 32;

	// Division by 100 as a multiply by ceil(2^32 / 100) and a shift by 32.
	// The error term of 4 times a 25-bit product stays far below 2^32.
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W = 26;
	localparam logic [RECIP_W-1:0] PctRecip = 26'd42949673;
	localparam int QUOT_W = 18;
	localparam logic [BASE_W-1:0] WidthMax = 16'hFFFF;

	// Lower breakpoint of each segment; the last slot is the hot clamp point.
	localparam logic signed [TEMP_W-1:0] TempBreak [8] =
		'{-9'sd10, 9'sd0, 9'sd10, 9'sd20, 9'sd30, 9'sd40, 9'sd60, 9'sd80};

	// Percentage at each breakpoint.
	localparam logic [PCT_W-1:0] PctTable [8] =
		'{9'd300, 9'd260, 9'd220, 9'd190, 9'd160, 9'd140, 9'd120, 9'd110};

	// Percent drop per degree in each segment. The segment from 60 to 80 C
	// falls by one half per degree and is handled by a shift instead.
	localparam logic [2:0] SegSlope [8] =
		'{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};

	localparam logic [SEG_W-1:0] SegHalf = 3'd6;

endpackage

// File: rtl/cold_start_enrichment_interp.sv
// Throughput: one item per cycle; the five-stage pipeline accepts a new item
// every cycle while the output is taken, and bubbles fill under a stall.
// Reset: arst_n clears all stage valid bits at once; payload is not reset.
// ----------------------------------------------------------------------------
// cold_start_enrichment_interp: cold-start fuel enrichment
// Interpolates an enrichment percentage from engine temperature in a fixed
// eight-point table and scales the base injector pulse width by it.
// ----------------------------------------------------------------------------
module cold_start_enrichment_interp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] base_pulse_width, [24:16] engine_temp, [31:25] zero
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] enriched_pulse_width, [24:16] enrichment_percent, [31:25] zero
	output logic [31:0] m_tdata
);
	import csei_pkg::*;

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	// Payload registers.
	logic [BASE_W-1:0]  base_s1, base_s2;
	logic [SEG_W-1:0]   seg_s1;
	logic [DT_W-1:0]    dt_s1;
	logic [PCT_W-1:0]   pct_s2, pct_s3, pct_s4, pct_s5;
	logic [PROD_W-1:0]  prod_s3;
	logic [QUOT_W-1:0]  quot_s4;
	logic [BASE_W-1:0]  width_s5;

	// Combinational values feeding each stage.
	logic signed [TEMP_W-1:0] temp_in;
	logic [SEG_W-1:0]         seg_in;
	logic [DT_W-1:0]          dt_in;
	logic signed [TEMP_W:0]   diff_in;
	logic [STEP_W-1:0]        step_s1;
	logic [PCT_W-1:0]         pct_next;
	logic [PROD_W+RECIP_W-1:0] scaled_s3;

	// A stage moves on when it is empty or the stage after it moves on.
	assign adv5 = !v_s5 || m_tready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	// Segment search with clamping at both ends of the table.
	assign temp_in = $signed(s_tdata[BASE_W +: TEMP_W]);
	always_comb begin
		priority if (temp_in >= TempBreak[6]) begin
			seg_in = 3'd6;
		end else if (temp_in >= TempBreak[5]) begin
			seg_in = 3'd5;
		end else if (temp_in >= TempBreak[4]) begin
			seg_in = 3'd4;
		end else if (temp_in >= TempBreak[3]) begin
			seg_in = 3'd3;
		end else if (temp_in >= TempBreak[2]) begin
			seg_in = 3'd2;
		end else if (temp_in >= TempBreak[1]) begin
			seg_in = 3'd1;
		end else begin
			seg_in = 3'd0;
		end
		diff_in = {temp_in[TEMP_W-1], temp_in} -
			{TempBreak[seg_in][TEMP_W-1], TempBreak[seg_in]};
		dt_in = DT_W'(diff_in);
		// Hot clamp selects the last table entry with no offset.
		if (temp_in >= TempBreak[7]) begin
			seg_in = 3'd7;
			dt_in = '0;
		end
		// Cold clamp holds the first entry with no offset.
		if (temp_in < TempBreak[0]) begin
			dt_in = '0;
		end
	end

	// Percent drop within the segment; the 60 to 80 C segment halves.
	always_comb begin
		if (seg_s1 == SegHalf) begin
			step_s1 = {{(STEP_W-DT_W+1){1'b0}}, dt_s1[DT_W-1:1]};
		end else begin
			step_s1 = {{(STEP_W-DT_W){1'b0}}, dt_s1} * {5'b0, SegSlope[seg_s1]};
		end
		pct_next = PctTable[seg_s1] - {{(PCT_W-STEP_W){1'b0}}, step_s1};
	end

	// Divide by one hundred through the reciprocal multiply.
	assign scaled_s3 = {{RECIP_W{1'b0}}, prod_s3} * {{PROD_W{1'b0}}, PctRecip};

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv1) begin
			base_s1 <= s_tdata[BASE_W-1:0];
			seg_s1 <= seg_in;
			dt_s1 <= dt_in;
		end
		if (adv2) begin
			base_s2 <= base_s1;
			pct_s2 <= pct_next;
		end
		if (adv3) begin
			pct_s3 <= pct_s2;
			prod_s3 <= {{PCT_W{1'b0}}, base_s2} * {{BASE_W{1'b0}}, pct_s2};
		end
		if (adv4) begin
			pct_s4 <= pct_s3;
			quot_s4 <= scaled_s3[RECIP_SHIFT +: QUOT_W];
		end
		if (adv5) begin
			pct_s5 <= pct_s4;
			if (quot_s4 > {{(QUOT_W-BASE_W){1'b0}}, WidthMax}) begin
				width_s5 <= WidthMax;
			end else begin
				width_s5 <= quot_s4[BASE_W-1:0];
			end
		end
	end

	// Output port.
	assign m_tvalid = v_s5;
	assign m_tdata = {{(DATA_W-BASE_W-PCT_W){1'b0}}, pct_s5, width_s5};

endmodule
